// ===== hw/rtl/huffman_byte_encoder_macros.svh =====
// Assertion macros for the Huffman byte encoder checker.
`ifndef HUFFMAN_BYTE_ENCODER_MACROS_SVH
`define HUFFMAN_BYTE_ENCODER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define HBE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hw/rtl/hbe_pkg.sv =====
// Package with types, constants and codes for the Huffman byte encoder.
package hbe_pkg;
   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int COUNT_WIDTH_DEF   = 32;
   localparam int MAX_CODE_LEN_DEF  = 64;
   localparam int CODE_BITS_W       = 64;
   localparam int CODE_LEN_W        = 7;

   typedef enum logic [1:0] {
      ACT_COUNT  = 2'd0,
      ACT_BUILD  = 2'd1,
      ACT_ENCODE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_EMPTY  = 2'd2
   } status_type;

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_CODE  = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic                   result_kind;
      logic [CODE_BITS_W-1:0] code_bits;
      logic [CODE_LEN_W-1:0]  code_length;
      logic [1:0]             status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_CNT_RD, S_CNT_WR, S_ENC_RD, S_ENC_OUT,
      S_SCAN_RD, S_SCAN_CHK, S_SORT_I, S_SORT_IR, S_SORT_IB, S_SORT_J,
      S_SORT_JR, S_SORT_JC, S_MRG_A, S_MRG_B, S_MRG_C, S_MRG_W, S_ROOT,
      S_WALK_POP, S_WALK_RD, S_WALK_CHK, S_WALK_P1, S_WALK_P0, S_DONE
   } state_type;
endpackage

// ===== hw/rtl/hbe_ram.sv =====
// Generic single-port RAM with registered read.
module hbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/huffman_byte_encoder.sv =====
// Top level of the Huffman byte encoder: histogram, tree build and code lookup.
//
// The block takes one word per command at an edge where start is high and busy
// is low, and it handles one command at a time. Right after reset busy stays
// high while the histogram and the code table are swept to zero. A count reads
// the histogram entry, then writes back the count plus one, saturating at the
// top. A clear sweeps the histogram at one entry per cycle. An encode reads
// the code table, then captures the result in a register; its result word is
// on the rsp_ ports for exactly one cycle under rsp_valid. The receiver cannot
// stall and must take every word in that cycle. A build is the long command:
// it sweeps the code table, reads each histogram entry to list the present
// symbols, sorts the list by falling count with a selection sort, and then
// merges the last two entries and sorts the list again after every merge. A
// depth-first walk of the tree with a stack memory then writes one code table
// entry per leaf whose length is at most MAX_CODE_LEN. The build result word
// is set in the done state and registered. All tables sit in single-port
// memories with a registered read, and busy stays high for the whole command.
module huffman_byte_encoder #(
   parameter int ALPHABET_SIZE = hbe_pkg::ALPHABET_SIZE_DEF,
   parameter int COUNT_WIDTH   = hbe_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_CODE_LEN  = hbe_pkg::MAX_CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hbe_pkg::req_type req_word,
   output logic             rsp_valid,
   output hbe_pkg::rsp_type rsp_word
);
   import hbe_pkg::*;

   localparam int SW  = $clog2(ALPHABET_SIZE);
   localparam int ND  = 2 * ALPHABET_SIZE;
   localparam int NW  = $clog2(ND);
   localparam int CHW = 2 * NW + 1;
   localparam int TW  = CODE_BITS_W + CODE_LEN_W + 1;
   // Walk lengths can exceed MAX_CODE_LEN on a deep tree, so they are kept
   // wide enough for any tree depth.
   localparam int WLW = (NW > CODE_LEN_W) ? NW : CODE_LEN_W;
   localparam int WKW = NW + CODE_BITS_W + WLW;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [NW:0] ALPHA_N = (NW+1)'(ALPHABET_SIZE);
   localparam logic [NW:0] ND_N    = (NW+1)'(ND);

   state_type state_ff, state_in;

   // Histogram memory.
   logic hc_we; logic [SW-1:0] hc_addr; logic [COUNT_WIDTH-1:0] hc_wd, hc_rd;
   // Node count, children and leaf symbol memories.
   logic nc_we; logic [NW-1:0] nc_addr; logic [COUNT_WIDTH-1:0] nc_wd, nc_rd;
   logic ch_we; logic [NW-1:0] ch_addr; logic [CHW-1:0] ch_wd, ch_rd;
   logic ls_we; logic [SW-1:0] ls_addr; logic [7:0] ls_wd, ls_rd;
   // Sorted list memory.
   logic sl_we; logic [SW-1:0] sl_addr; logic [NW-1:0] sl_wd, sl_rd;
   // Code table memory.
   logic ct_we; logic [SW-1:0] ct_addr; logic [TW-1:0] ct_wd, ct_rd;
   // Tree walk stack.
   logic wk_we; logic [NW-1:0] wk_addr; logic [WKW-1:0] wk_wd, wk_rd;

   hbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_hist (
      .clock, .we(hc_we), .addr(hc_addr), .wdata(hc_wd), .rdata(hc_rd));
   hbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ND)) u_ncnt (
      .clock, .we(nc_we), .addr(nc_addr), .wdata(nc_wd), .rdata(nc_rd));
   hbe_ram #(.WIDTH(CHW), .DEPTH(ND)) u_chld (
      .clock, .we(ch_we), .addr(ch_addr), .wdata(ch_wd), .rdata(ch_rd));
   hbe_ram #(.WIDTH(8), .DEPTH(ALPHABET_SIZE)) u_leaf (
      .clock, .we(ls_we), .addr(ls_addr), .wdata(ls_wd), .rdata(ls_rd));
   hbe_ram #(.WIDTH(NW), .DEPTH(ALPHABET_SIZE)) u_list (
      .clock, .we(sl_we), .addr(sl_addr), .wdata(sl_wd), .rdata(sl_rd));
   hbe_ram #(.WIDTH(TW), .DEPTH(ALPHABET_SIZE)) u_code (
      .clock, .we(ct_we), .addr(ct_addr), .wdata(ct_wd), .rdata(ct_rd));
   hbe_ram #(.WIDTH(WKW), .DEPTH(ND)) u_walk (
      .clock, .we(wk_we), .addr(wk_addr), .wdata(wk_wd), .rdata(wk_rd));

   // Working registers.
   logic [NW:0]  idx_ff, idx_in;     // sweep / scan index
   logic [NW:0]  n_ff, n_in;         // present symbols
   logic [NW:0]  size_ff, size_in;   // current list size
   logic [NW:0]  next_ff, next_in;   // next node index
   logic [NW:0]  i_ff, i_in;
   logic [NW:0]  j_ff, j_in;
   logic [NW-1:0] li_ff, li_in;      // node held for slot i, or merge branch one
   logic [COUNT_WIDTH-1:0] best_ff, best_in;
   logic [NW-1:0] na_ff, na_in;      // node of slot j, or merge branch zero
   logic [COUNT_WIDTH-1:0] ca_ff, ca_in;
   logic [NW:0]  sp_ff, sp_in;
   logic [CODE_BITS_W-1:0] wb_ff, wb_in;
   logic [WLW-1:0] wl_ff, wl_in;
   logic [CHW-1:0] wch_ff, wch_in;
   logic         ctclr_ff, ctclr_in; // clear sweep also covers code table
   logic         hclr_ff, hclr_in;   // clear sweep also covers histogram
   logic         build_ff, build_in; // sweep belongs to a build
   logic [7:0]   sym_ff, sym_in;
   logic         rv_ff, rv_in;
   rsp_type      rw_ff, rw_in;

   wire                 ch_int = ch_rd[CHW-1];
   wire [NW-1:0]        nd_rd  = wk_rd[WKW-1 -: NW];
   wire [COUNT_WIDTH:0] msum   = {1'b0, ca_ff} + {1'b0, nc_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         ctclr_ff <= 1'b1;
         hclr_ff  <= 1'b1;
         build_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ctclr_ff <= ctclr_in;
         hclr_ff  <= hclr_in;
         build_ff <= build_in;
         rv_ff    <= rv_in;
      end
      n_ff <= n_in; size_ff <= size_in; next_ff <= next_in;
      i_ff <= i_in; j_ff <= j_in; li_ff <= li_in; best_ff <= best_in;
      na_ff <= na_in; ca_ff <= ca_in; sp_ff <= sp_in; wb_ff <= wb_in;
      wl_ff <= wl_in; wch_ff <= wch_in;
      sym_ff <= sym_in; rw_ff <= rw_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (action_type'(req_word.action))
                  ACT_COUNT:  state_in = S_CNT_RD;
                  ACT_ENCODE: state_in = S_ENC_RD;
                  ACT_CLEAR,
                  ACT_BUILD:  state_in = S_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            if (idx_ff == ALPHA_N - 1'b1) state_in = build_ff ? S_SCAN_RD : S_IDLE;
         end
         S_CNT_RD:  state_in = S_CNT_WR;
         S_CNT_WR:  state_in = S_IDLE;
         S_ENC_RD:  state_in = S_ENC_OUT;
         S_ENC_OUT: state_in = S_IDLE;
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (idx_ff == ALPHA_N - 1'b1) begin
               state_in = (n_ff == '0 && hc_rd == '0) ? S_DONE : S_SORT_I;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SORT_I:   state_in = (i_ff + 1'b1 < size_ff) ? S_SORT_IR : S_MRG_A;
         S_SORT_IR:  state_in = S_SORT_IB;
         S_SORT_IB:  state_in = S_SORT_J;
         S_SORT_J:   state_in = (j_ff < size_ff) ? S_SORT_JR : S_SORT_I;
         S_SORT_JR:  state_in = S_SORT_JC;
         S_SORT_JC:  state_in = S_SORT_J;
         S_MRG_A: begin
            state_in = (size_ff > 1 && next_ff < ND_N) ? S_MRG_B : S_ROOT;
         end
         S_MRG_B:    state_in = S_MRG_C;
         S_MRG_C:    state_in = S_MRG_W;
         S_MRG_W:    state_in = S_SORT_I;
         S_ROOT:     state_in = S_WALK_POP;
         S_WALK_POP: state_in = (sp_ff == '0) ? S_DONE : S_WALK_RD;
         S_WALK_RD:  state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            state_in = (ch_int && sp_ff + 2'd2 <= ND_N) ? S_WALK_P1 : S_WALK_POP;
         end
         S_WALK_P1:  state_in = S_WALK_P0;
         S_WALK_P0:  state_in = S_WALK_POP;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control. The read data of an address set in one
   // state is on the memory output in the state after it.
   always_comb begin
      idx_in = idx_ff; n_in = n_ff; size_in = size_ff; next_in = next_ff;
      i_in = i_ff; j_in = j_ff; li_in = li_ff; best_in = best_ff;
      na_in = na_ff; ca_in = ca_ff; sp_in = sp_ff; wb_in = wb_ff;
      wl_in = wl_ff; wch_in = wch_ff;
      ctclr_in = ctclr_ff; hclr_in = hclr_ff; build_in = build_ff;
      sym_in = sym_ff; rv_in = 1'b0; rw_in = rw_ff;
      hc_we = 1'b0; hc_addr = idx_ff[SW-1:0]; hc_wd = '0;
      nc_we = 1'b0; nc_addr = '0; nc_wd = '0;
      ch_we = 1'b0; ch_addr = '0; ch_wd = '0;
      ls_we = 1'b0; ls_addr = '0; ls_wd = '0;
      sl_we = 1'b0; sl_addr = '0; sl_wd = '0;
      ct_we = 1'b0; ct_addr = idx_ff[SW-1:0]; ct_wd = '0;
      wk_we = 1'b0; wk_addr = '0; wk_wd = '0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            sym_in = req_word.symbol;
            hclr_in = (action_type'(req_word.action) == ACT_CLEAR);
            ctclr_in = (action_type'(req_word.action) == ACT_BUILD);
            build_in = (action_type'(req_word.action) == ACT_BUILD);
         end
         S_CLEAR: begin
            hc_we = hclr_ff;
            ct_we = ctclr_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == ALPHA_N - 1'b1) begin
               idx_in = '0;
               n_in = '0;
            end
         end
         S_CNT_RD: hc_addr = sym_ff[SW-1:0];
         S_CNT_WR: begin
            hc_addr = sym_ff[SW-1:0];
            hc_we = ({1'b0, sym_ff} < 9'(ALPHABET_SIZE)) && (hc_rd != CMAX);
            hc_wd = hc_rd + 1'b1;
         end
         S_ENC_RD: ct_addr = sym_ff[SW-1:0];
         S_ENC_OUT: begin
            rv_in = 1'b1;
            rw_in.result_kind = KIND_CODE;
            if ({1'b0, sym_ff} < 9'(ALPHABET_SIZE) && ct_rd[0]) begin
               rw_in.code_bits = ct_rd[TW-1 -: CODE_BITS_W];
               rw_in.code_length = ct_rd[CODE_LEN_W:1];
               rw_in.status = ST_OK;
            end else begin
               rw_in.code_bits = '0;
               rw_in.code_length = '0;
               rw_in.status = ST_ABSENT;
            end
         end
         S_SCAN_RD: hc_addr = idx_ff[SW-1:0];
         S_SCAN_CHK: begin
            // Present symbols become leaves in ascending byte order.
            if (hc_rd != '0) begin
               ls_we = 1'b1; ls_addr = n_ff[SW-1:0]; ls_wd = 8'(idx_ff);
               nc_we = 1'b1; nc_addr = n_ff[NW-1:0]; nc_wd = hc_rd;
               ch_we = 1'b1; ch_addr = n_ff[NW-1:0]; ch_wd = '0;
               sl_we = 1'b1; sl_addr = n_ff[SW-1:0]; sl_wd = n_ff[NW-1:0];
               n_in = n_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            size_in = n_in; next_in = n_in; i_in = '0;
         end
         // Slot i: fetch its node, then that node's count as the running best.
         S_SORT_I: sl_addr = i_ff[SW-1:0];
         S_SORT_IR: begin
            li_in = sl_rd; nc_addr = sl_rd; j_in = i_ff + 1'b1;
         end
         S_SORT_IB: best_in = nc_rd;
         S_SORT_J: begin
            sl_addr = j_ff[SW-1:0];
            if (j_ff >= size_ff) begin
               // The node held for slot i is final once the scan of j ends.
               sl_we = 1'b1; sl_addr = i_ff[SW-1:0]; sl_wd = li_ff;
               i_in = i_ff + 1'b1;
            end
         end
         S_SORT_JR: begin
            na_in = sl_rd; nc_addr = sl_rd;
         end
         S_SORT_JC: begin
            // A strictly larger count swaps slots i and j.
            if (nc_rd > best_ff) begin
               best_in = nc_rd;
               sl_we = 1'b1; sl_addr = j_ff[SW-1:0]; sl_wd = li_ff;
               li_in = na_ff;
            end
            j_in = j_ff + 1'b1;
         end
         S_MRG_A: begin
            sl_addr = SW'(size_ff - 1'b1);
            if (!(size_ff > 1 && next_ff < ND_N)) sl_addr = '0;
         end
         S_MRG_B: begin
            na_in = sl_rd; nc_addr = sl_rd;
            sl_addr = SW'(size_ff - 2'd2);
         end
         S_MRG_C: begin
            ca_in = nc_rd; li_in = sl_rd; nc_addr = sl_rd;
         end
         S_MRG_W: begin
            // The last entry is the zero branch, the one before it the one branch.
            nc_we = 1'b1; nc_addr = next_ff[NW-1:0];
            nc_wd = msum[COUNT_WIDTH] ? CMAX : msum[COUNT_WIDTH-1:0];
            ch_we = 1'b1; ch_addr = next_ff[NW-1:0];
            ch_wd = {1'b1, li_ff, na_ff};
            sl_we = 1'b1; sl_addr = SW'(size_ff - 2'd2);
            sl_wd = next_ff[NW-1:0];
            size_in = size_ff - 1'b1; next_in = next_ff + 1'b1; i_in = '0;
         end
         S_ROOT: begin
            // List slot zero holds the root; a lone leaf gets length zero.
            wk_we = 1'b1; wk_addr = '0; wk_wd = {sl_rd, {CODE_BITS_W{1'b0}}, {WLW{1'b0}}};
            sp_in = 1;
         end
         S_WALK_POP: begin
            wk_addr = SW'(sp_ff - 1'b1);
            if (sp_ff != '0) sp_in = sp_ff - 1'b1;
         end
         S_WALK_RD: begin
            ch_addr = nd_rd;
            ls_addr = nd_rd[SW-1:0];
            wb_in = wk_rd[WLW +: CODE_BITS_W];
            wl_in = wk_rd[WLW-1:0];
         end
         S_WALK_CHK: begin
            wch_in = ch_rd;
            if (!ch_int) begin
               ct_addr = ls_rd[SW-1:0];
               ct_we = (wl_ff <= WLW'(MAX_CODE_LEN));
               ct_wd = {wb_ff, wl_ff[CODE_LEN_W-1:0], 1'b1};
            end
         end
         S_WALK_P1: begin
            wk_we = 1'b1; wk_addr = sp_ff[NW-1:0];
            wk_wd = {wch_ff[2*NW-1:NW], wb_ff[CODE_BITS_W-2:0], 1'b1, wl_ff + 1'b1};
            sp_in = sp_ff + 1'b1;
         end
         S_WALK_P0: begin
            wk_we = 1'b1; wk_addr = sp_ff[NW-1:0];
            wk_wd = {wch_ff[NW-1:0], wb_ff[CODE_BITS_W-2:0], 1'b0, wl_ff + 1'b1};
            sp_in = sp_ff + 1'b1;
         end
         S_DONE: begin
            rv_in = 1'b1;
            rw_in.result_kind = KIND_BUILD;
            rw_in.code_bits = '0;
            rw_in.code_length = '0;
            rw_in.status = (n_ff == '0) ? ST_EMPTY : ST_OK;
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rw_ff;
endmodule

// ===== hw/rtl/hbe_checker.sv =====
// Port-level checker for the Huffman byte encoder, bound to the top level.
`include "huffman_byte_encoder_macros.svh"
module hbe_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input hbe_pkg::req_type req_word,
   input logic             rsp_valid,
   input hbe_pkg::rsp_type rsp_word
);
   import hbe_pkg::*;
   `HBE_ASSERT_IMP(a_build_zero, clock, reset, rsp_valid && rsp_word.result_kind == KIND_BUILD, rsp_word.code_bits == '0 && rsp_word.code_length == '0, "build word with code")
   `HBE_ASSERT_IMP(a_absent_zero, clock, reset, rsp_valid && rsp_word.status == ST_ABSENT, rsp_word.code_bits == '0 && rsp_word.code_length == '0, "absent word with code")
   `HBE_ASSERT_NXT(a_one_cycle, clock, reset, rsp_valid, !rsp_valid, "result held two cycles")
   `HBE_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted command without busy")
endmodule

bind huffman_byte_encoder hbe_checker u_hbe_checker (.*);

// ===== verif/huffman_byte_encoder_tb.sv =====
// Testbench for the Huffman byte encoder: random and directed commands checked by a predictor.
module huffman_byte_encoder_tb;
   import hbe_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int ITEM_TARGET = 1250;
   localparam int NODE_SLOTS  = 2 * ALPHABET_SIZE_DEF;
   localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   always #2 clock = ~clock;

   huffman_byte_encoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   // Commands waiting to be driven, and result words waiting to be seen.
   req_type pending_cmds[$];
   rsp_type expected_words[$];
   int      errors = 0;
   int      accepted = 0;
   int      cycles = 0;

   // Shadow copy of the histogram, the scratch tree and the code table.
   logic [31:0] hist[ALPHABET_SIZE_DEF];
   logic [31:0] weight[NODE_SLOTS];
   int          zero_kid[NODE_SLOTS];
   int          one_kid[NODE_SLOTS];
   bit          is_inner[NODE_SLOTS];
   int          order[ALPHABET_SIZE_DEF];
   int          leaf_sym[ALPHABET_SIZE_DEF];
   logic [63:0] code_bits_tbl[ALPHABET_SIZE_DEF];
   int          code_len_tbl[ALPHABET_SIZE_DEF];
   bit          code_known[ALPHABET_SIZE_DEF];

   initial begin
      for (int s = 0; s < ALPHABET_SIZE_DEF; s++) begin
         hist[s] = '0;
         code_known[s] = 1'b0;
         code_len_tbl[s] = 0;
         code_bits_tbl[s] = '0;
      end
   end

   // Selection sort over the first n list slots: a swap happens only when a
   // strictly larger weight shows up, so an equal weight never displaces the held one.
   function automatic void sort_by_weight(int n);
      logic [31:0] best;
      int t;
      for (int i = 0; i + 1 < n; i++) begin
         best = weight[order[i]];
         for (int j = i + 1; j < n; j++) begin
            if (weight[order[j]] > best) begin
               t = order[i];
               best = weight[order[j]];
               order[i] = order[j];
               order[j] = t;
            end
         end
      end
   endfunction

   // Rebuild the code table from the histogram; returns the build status.
   function automatic status_type build_codes();
      int n, size, nxt, a, b, nd, len;
      logic [32:0] sum;
      logic [63:0] bits;
      int stk_node[$];
      logic [63:0] stk_bits[$];
      int stk_len[$];
      n = 0;
      for (int s = 0; s < ALPHABET_SIZE_DEF; s++) begin
         code_known[s] = 1'b0;
         code_len_tbl[s] = 0;
         code_bits_tbl[s] = '0;
      end
      for (int s = 0; s < ALPHABET_SIZE_DEF; s++) begin
         if (hist[s] != 0) begin
            leaf_sym[n] = s;
            weight[n] = hist[s];
            is_inner[n] = 1'b0;
            order[n] = n;
            n++;
         end
      end
      if (n == 0) return ST_EMPTY;
      sort_by_weight(n);
      size = n;
      nxt = n;
      // Merge the two lightest entries; the last one becomes the 0 branch.
      while (size > 1 && nxt < NODE_SLOTS) begin
         a = order[size-1];
         b = order[size-2];
         zero_kid[nxt] = a;
         one_kid[nxt] = b;
         is_inner[nxt] = 1'b1;
         sum = {1'b0, weight[a]} + {1'b0, weight[b]};
         weight[nxt] = sum[32] ? COUNT_TOP : sum[31:0];
         size--;
         order[size-1] = nxt;
         nxt++;
         sort_by_weight(size);
      end
      // Depth-first walk; a lone symbol ends up with length zero.
      stk_node.push_back(order[0]);
      stk_bits.push_back('0);
      stk_len.push_back(0);
      while (stk_node.size() > 0) begin
         nd = stk_node.pop_back();
         bits = stk_bits.pop_back();
         len = stk_len.pop_back();
         if (!is_inner[nd]) begin
            if (len <= MAX_CODE_LEN_DEF) begin
               code_bits_tbl[leaf_sym[nd % ALPHABET_SIZE_DEF]] = bits;
               code_len_tbl[leaf_sym[nd % ALPHABET_SIZE_DEF]] = len;
               code_known[leaf_sym[nd % ALPHABET_SIZE_DEF]] = 1'b1;
            end
         end else if (stk_node.size() + 2 <= NODE_SLOTS) begin
            stk_node.push_back(one_kid[nd]);
            stk_bits.push_back({bits[62:0], 1'b1});
            stk_len.push_back(len + 1);
            stk_node.push_back(zero_kid[nd]);
            stk_bits.push_back({bits[62:0], 1'b0});
            stk_len.push_back(len + 1);
         end
      end
      return ST_OK;
   endfunction

   // Apply one accepted command to the shadow state and queue its result.
   task automatic apply_command(req_type cmd);
      rsp_type w;
      w = '0;
      case (action_type'(cmd.action))
         ACT_COUNT: begin
            if (hist[cmd.symbol] != COUNT_TOP) hist[cmd.symbol] = hist[cmd.symbol] + 32'd1;
         end
         ACT_CLEAR: begin
            for (int s = 0; s < ALPHABET_SIZE_DEF; s++) hist[s] = '0;
         end
         ACT_BUILD: begin
            w.result_kind = KIND_BUILD;
            w.status = build_codes();
            expected_words.push_back(w);
         end
         default: begin
            w.result_kind = KIND_CODE;
            if (code_known[cmd.symbol]) begin
               w.code_bits = code_bits_tbl[cmd.symbol];
               w.code_length = code_len_tbl[cmd.symbol][CODE_LEN_W-1:0];
               w.status = ST_OK;
            end else begin
               w.status = ST_ABSENT;
            end
            expected_words.push_back(w);
         end
      endcase
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   // Driver: a word is taken at an edge where start is high and busy low.
   // A held command stays on the port until taken; otherwise the next one
   // is offered unless this cycle is chosen to idle. Accepted words 400 to
   // 649 run without any idling.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_command(req_word);
            void'(pending_cmds.pop_front());
            accepted++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_cmds.size() > 0 &&
                      ((accepted >= 400 && accepted < 650) || $urandom_range(99) >= 27)) begin
            start <= 1'b1;
            req_word <= pending_cmds[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every result word must match the oldest expected word.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report("unexpected word, kind", 64'(rsp_word.result_kind), 64'd0);
         end else begin
            if (rsp_word.result_kind !== expected_words[0].result_kind)
               report("result_kind", 64'(rsp_word.result_kind),
                      64'(expected_words[0].result_kind));
            if (rsp_word.code_bits !== expected_words[0].code_bits)
               report("code_bits", rsp_word.code_bits, expected_words[0].code_bits);
            if (rsp_word.code_length !== expected_words[0].code_length)
               report("code_length", 64'(rsp_word.code_length),
                      64'(expected_words[0].code_length));
            if (rsp_word.status !== expected_words[0].status)
               report("status", 64'(rsp_word.status), 64'(expected_words[0].status));
            void'(expected_words.pop_front());
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("huffman_byte_encoder_tb failed");
         $finish;
      end
   end

   task automatic queue_cmd(action_type act, int sym);
      req_type c;
      c.action = act;
      c.symbol = sym[7:0];
      pending_cmds.push_back(c);
   endtask

   initial begin
      int d, k;
      int chosen[$];
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table after reset, empty build, lone symbol,
      // extreme bytes, ties, a stale table after further counts, and clear.
      queue_cmd(ACT_ENCODE, 0);
      queue_cmd(ACT_BUILD, 8'hFF);
      queue_cmd(ACT_COUNT, 0);
      queue_cmd(ACT_BUILD, 0);
      queue_cmd(ACT_ENCODE, 0);
      queue_cmd(ACT_ENCODE, 255);
      queue_cmd(ACT_COUNT, 255);
      queue_cmd(ACT_COUNT, 128);
      queue_cmd(ACT_COUNT, 0);
      queue_cmd(ACT_BUILD, 0);
      queue_cmd(ACT_ENCODE, 0);
      queue_cmd(ACT_ENCODE, 128);
      queue_cmd(ACT_ENCODE, 255);
      // Counts after a build leave the table as it was.
      queue_cmd(ACT_COUNT, 85);
      queue_cmd(ACT_ENCODE, 85);
      queue_cmd(ACT_CLEAR, 170);
      queue_cmd(ACT_ENCODE, 255);
      queue_cmd(ACT_BUILD, 0);
      queue_cmd(ACT_ENCODE, 0);
      queue_cmd(ACT_COUNT, 170);
      queue_cmd(ACT_COUNT, 170);
      queue_cmd(ACT_COUNT, 85);
      queue_cmd(ACT_BUILD, 0);
      queue_cmd(ACT_ENCODE, 170);
      queue_cmd(ACT_ENCODE, 85);

      // Random part: mostly clear, count, build, encode sequences over a few
      // symbols, with short bursts of random noise in between.
      while (pending_cmds.size() < ITEM_TARGET) begin
         if ($urandom_range(99) < 73) begin
            d = ($urandom_range(14) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            chosen.delete();
            for (int i = 0; i < d; i++) chosen.push_back($urandom_range(255));
            queue_cmd(ACT_CLEAR, $urandom_range(255));
            foreach (chosen[i]) queue_cmd(ACT_COUNT, chosen[i]);
            k = $urandom_range(3 * d);
            for (int i = 0; i < k; i++)
               queue_cmd(ACT_COUNT, chosen[$urandom_range(d - 1)]);
            queue_cmd(ACT_BUILD, $urandom_range(255));
            k = $urandom_range(8, 2);
            for (int i = 0; i < k; i++) begin
               pick = ($urandom_range(3) == 0) ? $urandom_range(255)
                                               : chosen[$urandom_range(d - 1)];
               queue_cmd(ACT_ENCODE, pick);
            end
         end else begin
            k = $urandom_range(6, 1);
            for (int i = 0; i < k; i++)
               queue_cmd(action_type'($urandom_range(3)), $urandom_range(255));
         end
      end

      wait (pending_cmds.size() == 0 && !start);
      wait (expected_words.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("huffman_byte_encoder_tb passed");
      end else begin
         $display("huffman_byte_encoder_tb failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hbe_pkg.sv
hw/rtl/hbe_ram.sv
hw/rtl/huffman_byte_encoder.sv
hw/rtl/hbe_checker.sv
verif/huffman_byte_encoder_tb.sv
